FILE: src/pcxd_pkg.sv
// ----------------------------------------------------------------------------
// pcxd_pkg
// shared constants and types of the pcx planar 4-bit run-length decoder
// ----------------------------------------------------------------------------
package pcxd_pkg;

   localparam int MAX_PLANE_BYTES = 128;
   localparam int PLANES          = 4;
   localparam int STORE_W         = 8 * (PLANES - 1);
   localparam int GROUP_PIXELS    = 8;
   localparam int CFG_W           = 11;
   localparam int BASE_W          = 14;
   localparam int LINE_W          = 10;
   localparam int RUN_W           = 6;

   localparam logic [7:0]       RUN_FLAG       = 8'hC0;
   localparam logic [1:0]       LAST_PLANE     = 2'(PLANES - 1);
   localparam logic [CFG_W-1:0] HEIGHT_LIMIT   = 11'd1024;
   localparam logic [CFG_W-1:0] WIDTH_RESET    = 11'd320;
   localparam logic [7:0]       PLANE_B_RESET  = 8'd40;
   localparam logic [CFG_W-1:0] HEIGHT_RESET   = 11'd200;

   typedef enum logic [1:0] {
      CSR_IMAGE_WIDTH      = 2'd0,
      CSR_PLANE_LINE_BYTES = 2'd1,
      CSR_IMAGE_HEIGHT     = 2'd2
   } csr_index_type;

endpackage

FILE: src/pcx_rle_planar_4bit_decoder_core.sv
// ----------------------------------------------------------------------------
// pcx_rle_planar_4bit_decoder_core
// pcx run-length decoder for four-plane 4-bit images, one coded byte per item
// ----------------------------------------------------------------------------
// Coded bytes enter on the req_ channel, one item at a time. A literal byte
// is accepted, read from the line store and then updated; in a run of n
// bytes, every decoded byte repeats the read and update, because each does a
// read-modify-write of the line store that holds planes 0 to 2. A count byte
// is only accepted. Each plane-3 byte inside the width gives one rsp_ item of
// up to eight pixels; results are held one deep before the output register so
// that run_last can be set on the final one, and the decoder stalls while the
// output side does not take them. Configuration is written on the csr_
// channel, which is always ready. The line store needs no clearing.
// ----------------------------------------------------------------------------
module pcx_rle_planar_4bit_decoder_core #(
   parameter int MAX_PLANE_BYTES = pcxd_pkg::MAX_PLANE_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_code_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_pixel_group,
   output logic [3:0]  rsp_pixel_count,
   output logic        rsp_line_end,
   output logic        rsp_frame_end,
   output logic        rsp_run_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_data
);

   localparam int POS_W  = (MAX_PLANE_BYTES > 1) ? $clog2(MAX_PLANE_BYTES) : 1;
   localparam int CFG_W  = pcxd_pkg::CFG_W;
   localparam int BASE_W = pcxd_pkg::BASE_W;
   localparam int RUN_W  = pcxd_pkg::RUN_W;
   localparam int LINE_W = pcxd_pkg::LINE_W;
   localparam int SW     = pcxd_pkg::STORE_W;
   localparam logic [CFG_W-1:0] PLB_MAX = CFG_W'(MAX_PLANE_BYTES);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EXEC
   } state_type;

   state_type         state_ff, state_in;
   logic [CFG_W-1:0]  width_ff, width_in;
   logic [7:0]        plb_ff, plb_in;
   logic [CFG_W-1:0]  height_ff, height_in;
   logic [RUN_W-1:0]  run_left_ff, run_left_in;
   logic              await_ff, await_in;
   logic [1:0]        plane_ff, plane_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic [RUN_W-1:0]  reps_ff, reps_in;
   logic [7:0]        value_ff, value_in;
   logic              pend_valid_ff, pend_valid_in;
   logic              pend_final_ff, pend_final_in;
   logic [31:0]       pend_group_ff, pend_group_in;
   logic [3:0]        pend_count_ff, pend_count_in;
   logic              pend_lend_ff, pend_lend_in;
   logic              pend_fend_ff, pend_fend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_group_ff, rsp_group_in;
   logic [3:0]        rsp_count_ff, rsp_count_in;
   logic              rsp_lend_ff, rsp_lend_in;
   logic              rsp_fend_ff, rsp_fend_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [SW-1:0]     store_rd;
   logic [SW-1:0]     store_wr;
   logic              store_we;

   logic [CFG_W-1:0]  plb_eff;
   logic [CFG_W-1:0]  height_eff;
   logic [BASE_W-1:0] base;
   logic [BASE_W-1:0] w_even;
   logic [BASE_W-1:0] diff;
   logic [3:0]        cnt;
   logic [31:0]       group;
   logic              plane_end;
   logic              last_line;
   logic              lend;
   logic              exec_emit;
   logic              out_free;
   logic              go;
   logic              push;
   logic              last_rep;
   logic              req_take;

   pcxd_ram #(
      .WIDTH (SW),
      .DEPTH (MAX_PLANE_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (pos_ff),
      .wr_data (store_wr),
      .rd_addr (pos_ff),
      .rd_data (store_rd)
   );

   always_comb begin
      plb_eff = {3'b000, plb_ff};
      if (plb_eff == '0) begin
         plb_eff = CFG_W'(1);
      end else if (plb_eff > PLB_MAX) begin
         plb_eff = PLB_MAX;
      end
      height_eff = height_ff;
      if (height_eff == '0) begin
         height_eff = CFG_W'(1);
      end else if (height_eff > pcxd_pkg::HEIGHT_LIMIT) begin
         height_eff = pcxd_pkg::HEIGHT_LIMIT;
      end
   end

   always_comb begin
      base      = BASE_W'(pos_ff) << 3;
      w_even    = BASE_W'({width_ff[CFG_W-1:1], 1'b0});
      diff      = w_even - base;
      cnt       = (diff > BASE_W'(8)) ? 4'd8 : diff[3:0];
      plane_end = (CFG_W'(pos_ff) + CFG_W'(1)) >= plb_eff;
      last_line = (CFG_W'(line_ff) + CFG_W'(1)) >= height_eff;
      lend      = ((base + BASE_W'(8)) >= w_even) || plane_end;
      for (int k = 0; k < pcxd_pkg::GROUP_PIXELS; k++) begin
         if (k < int'(cnt)) begin
            group[4*k +: 4] = {value_ff[7-k], store_rd[23-k], store_rd[15-k], store_rd[7-k]};
         end else begin
            group[4*k +: 4] = 4'h0;
         end
      end
   end

   always_comb begin
      case (plane_ff)
         2'd0:    store_wr = {store_rd[23:8], value_ff};
         2'd1:    store_wr = {store_rd[23:16], value_ff, store_rd[7:0]};
         default: store_wr = {value_ff, store_rd[15:0]};
      endcase
   end

   assign exec_emit = (state_ff == ST_EXEC) && (plane_ff == pcxd_pkg::LAST_PLANE)
                      && (base < w_even);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign go        = (state_ff == ST_EXEC) && (!exec_emit || !pend_valid_ff || out_free);
   assign push      = pend_valid_ff && out_free && (pend_final_ff || (go && exec_emit));
   assign last_rep  = (reps_ff == RUN_W'(1));
   assign store_we  = (state_ff == ST_EXEC) && (plane_ff != pcxd_pkg::LAST_PLANE);
   assign req_take  = req_valid && req_ready;

   always_comb begin
      state_in      = state_ff;
      width_in      = width_ff;
      plb_in        = plb_ff;
      height_in     = height_ff;
      run_left_in   = run_left_ff;
      await_in      = await_ff;
      plane_in      = plane_ff;
      pos_in        = pos_ff;
      line_in       = line_ff;
      reps_in       = reps_ff;
      value_in      = value_ff;
      pend_valid_in = pend_valid_ff;
      pend_final_in = pend_final_ff;
      pend_group_in = pend_group_ff;
      pend_count_in = pend_count_ff;
      pend_lend_in  = pend_lend_ff;
      pend_fend_in  = pend_fend_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_group_in  = rsp_group_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_lend_in   = rsp_lend_ff;
      rsp_fend_in   = rsp_fend_ff;
      rsp_last_in   = rsp_last_ff;

      if (csr_valid) begin
         case (csr_index)
            pcxd_pkg::CSR_IMAGE_WIDTH:      width_in  = csr_data;
            pcxd_pkg::CSR_PLANE_LINE_BYTES: plb_in    = csr_data[7:0];
            pcxd_pkg::CSR_IMAGE_HEIGHT:     height_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               value_in = req_code_byte;
               if (!await_ff && (req_code_byte >= pcxd_pkg::RUN_FLAG)) begin
                  run_left_in = req_code_byte[RUN_W-1:0];
                  await_in    = 1'b1;
               end else begin
                  reps_in     = await_ff ? run_left_ff : RUN_W'(1);
                  run_left_in = '0;
                  await_in    = 1'b0;
                  if (!await_ff || (run_left_ff != '0)) begin
                     state_in = ST_READ;
                  end
               end
            end
         end
         ST_READ: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (go) begin
               reps_in  = reps_ff - RUN_W'(1);
               state_in = last_rep ? ST_IDLE : ST_READ;
               if (plane_end) begin
                  pos_in = '0;
                  if (plane_ff == pcxd_pkg::LAST_PLANE) begin
                     plane_in = 2'd0;
                     line_in  = last_line ? '0 : line_ff + LINE_W'(1);
                  end else begin
                     plane_in = plane_ff + 2'd1;
                  end
               end else begin
                  pos_in = pos_ff + POS_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_group_in = pend_group_ff;
         rsp_count_in = pend_count_ff;
         rsp_lend_in  = pend_lend_ff;
         rsp_fend_in  = pend_fend_ff;
         rsp_last_in  = pend_final_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (go && exec_emit) begin
         pend_valid_in = 1'b1;
         pend_final_in = last_rep;
         pend_group_in = group;
         pend_count_in = cnt;
         pend_lend_in  = lend;
         pend_fend_in  = lend && last_line;
      end else if (push) begin
         pend_valid_in = 1'b0;
      end else if (go && last_rep && pend_valid_ff) begin
         pend_final_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         width_ff      <= pcxd_pkg::WIDTH_RESET;
         plb_ff        <= pcxd_pkg::PLANE_B_RESET;
         height_ff     <= pcxd_pkg::HEIGHT_RESET;
         run_left_ff   <= '0;
         await_ff      <= 1'b0;
         plane_ff      <= '0;
         pos_ff        <= '0;
         line_ff       <= '0;
         reps_ff       <= '0;
         pend_valid_ff <= 1'b0;
         pend_final_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         width_ff      <= width_in;
         plb_ff        <= plb_in;
         height_ff     <= height_in;
         run_left_ff   <= run_left_in;
         await_ff      <= await_in;
         plane_ff      <= plane_in;
         pos_ff        <= pos_in;
         line_ff       <= line_in;
         reps_ff       <= reps_in;
         pend_valid_ff <= pend_valid_in;
         pend_final_ff <= pend_final_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      value_ff      <= value_in;
      pend_group_ff <= pend_group_in;
      pend_count_ff <= pend_count_in;
      pend_lend_ff  <= pend_lend_in;
      pend_fend_ff  <= pend_fend_in;
      rsp_group_ff  <= rsp_group_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_lend_ff   <= rsp_lend_in;
      rsp_fend_ff   <= rsp_fend_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_ready       = (state_ff == ST_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_group = rsp_group_ff;
   assign rsp_pixel_count = rsp_count_ff;
   assign rsp_line_end    = rsp_lend_ff;
   assign rsp_frame_end   = rsp_fend_ff;
   assign rsp_run_last    = rsp_last_ff;

   // a held result that is not yet final only exists while a run is decoding
   a_pend_open_busy: assert property (@(posedge clock) disable iff (reset)
      (pend_valid_ff && !pend_final_ff) |-> (state_ff != ST_IDLE))
      else $error("open pending item while idle");

   // an item leaves without run_last only when a newer one replaces it
   a_push_not_last: assert property (@(posedge clock) disable iff (reset)
      (push && !pend_final_ff) |-> (go && exec_emit))
      else $error("pending item pushed without successor");

   // reps left is never zero while decoding
   a_reps_live: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_READ) || (state_ff == ST_EXEC)) |-> (reps_ff != '0))
      else $error("decoding with no reps left");

   // a stalled execute step keeps its store address
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EXEC) && !go) |=> ((state_ff == ST_EXEC) && $stable(pos_ff)))
      else $error("execute stall lost its address");

endmodule

FILE: src/pcxd_ram.sv
// ----------------------------------------------------------------------------
// pcxd_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module pcxd_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 128
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
